/* rtl/core/mcff_pkg.sv */
// Shared types and codes for the multichannel frame FIFO.
`timescale 1ns / 1ps
`default_nettype none

package mcff_pkg;

  // Channel count register width, partial-frame position width and capacity width.
  localparam int unsigned ChW  = 4;
  localparam int unsigned WchW = 3;
  localparam int unsigned CapW = 13;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_WRITTEN   = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_READ_DATA = 3'd2,
    ST_SILENCE   = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  typedef enum logic {
    CFG_CHANNELS = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_CLEAR,
    S_SETTLE_A,
    S_SETTLE_B
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic wr;
    logic rd;
    logic clr;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/multichannel_frame_fifo.sv */
// Top level of the multichannel frame FIFO: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Frame-granular ring of interleaved 32-bit audio samples. Issue a command by
// raising start_i while busy_o is low: write one sample, read one frame, or
// clear. Every accepted command returns its results on result_valid_o, one
// word per cycle, with last_o on the final word; the receiver cannot stall,
// so sample each word in the cycle it is shown. A write returns one word in
// the cycle after it is executed. A read returns channel_count words on
// consecutive cycles, each in the cycle after its read step, through the
// registered read port of the sample store. An unknown command is dropped and
// returns nothing. A frame is admitted or dropped as a whole on its first
// sample, keeping one frame slot in reserve, and becomes readable after its
// last sample; a read with nothing stored returns silence. Write configuration
// only while idle: each write empties the ring and holds busy_o high through
// S_SETTLE_A and S_SETTLE_B while the ring geometry (capacity clamped to fit
// the store) is recomputed. The store has no clearing pass; a read touches
// only entries of complete frames.
module multichannel_frame_fifo #(
  parameter int unsigned STORE_DEPTH  = 4096,
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [1:0]                cmd_i,
  input  wire logic [31:0]               sample_i,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [mcff_pkg::CapW-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output logic [2:0]                     status_o,
  output logic [31:0]                    sample_out_o,
  output logic                           last_o,
  output logic [12:0]                    frames_readable_o,
  output logic [11:0]                    frames_writable_o
);
  import mcff_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequence each command: accept, execute, then advance to the next word.
  mcff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd),
    .busy_o      (busy_o)
  );

  // Hold pointers, frame counts, the sample store and the result register.
  mcff_datapath #(
    .STORE_DEPTH  (STORE_DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .dp_cmd_i          (dp_cmd),
    .dp_status_o       (dp_status),
    .sample_i          (sample_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .sample_out_o      (sample_out_o),
    .last_o            (last_o),
    .frames_readable_o (frames_readable_o),
    .frames_writable_o (frames_writable_o)
  );

  // A write or clear word, with last_o set, follows its accept through the execute state and the result register.
  a_single_word_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == CMD_WRITE || cmd_i == CMD_CLEAR))
    |-> ##2 (result_valid_o && last_o))
    else $error("write or clear word missing after accept");

endmodule

`default_nettype wire

/* rtl/core/mcff_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mcff_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mcff_ctrl.sv */
// Controller state machine: sequences write, read and clear operations and the settle after a register write.
`timescale 1ns / 1ps
`default_nettype none

module mcff_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [1:0]           cmd_i,
  input  wire logic                 cfg_we_i,
  input  wire mcff_pkg::dp_status_t dp_status_i,
  output mcff_pkg::dp_cmd_t         dp_cmd_o,
  output logic                      busy_o
);
  import mcff_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i && !cfg_we_i) begin
          case (cmd_i)
            CMD_WRITE: begin
              dp_cmd_o.load = 1'b1;
              state_d       = S_WRITE;
            end
            CMD_READ: begin
              dp_cmd_o.load = 1'b1;
              state_d       = S_READ;
            end
            CMD_CLEAR: begin
              dp_cmd_o.load = 1'b1;
              state_d       = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        dp_cmd_o.wr = 1'b1;
        state_d     = S_IDLE;
      end
      S_READ: begin
        dp_cmd_o.rd = 1'b1;
        if (dp_status_i.rd_last) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        dp_cmd_o.clr = 1'b1;
        state_d      = S_IDLE;
      end
      S_SETTLE_A: state_d = S_SETTLE_B;
      S_SETTLE_B: state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
    // hold off items until the derived ring geometry has caught up
    if (cfg_we_i) begin
      state_d = S_SETTLE_A;
    end
  end

  assign busy_o = (state_q != S_IDLE) || cfg_we_i;

endmodule

`default_nettype wire

/* rtl/core/mcff_datapath.sv */
// Datapath: ring pointers, frame accounting, sample store and result register.
`timescale 1ns / 1ps
`default_nettype none

module mcff_datapath #(
  parameter int unsigned STORE_DEPTH  = 4096,
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mcff_pkg::dp_cmd_t       dp_cmd_i,
  output mcff_pkg::dp_status_t         dp_status_o,
  input  wire logic [31:0]             sample_i,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [mcff_pkg::CapW-1:0] cfg_data_i,
  output logic                         result_valid_o,
  output logic [2:0]                   status_o,
  output logic [31:0]                  sample_out_o,
  output logic                         last_o,
  output logic [12:0]                  frames_readable_o,
  output logic [11:0]                  frames_writable_o
);
  import mcff_pkg::*;

  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned SW   = AW + 1;
  localparam int unsigned CMPW = (SW > CapW) ? SW : CapW;

  localparam int unsigned EffChRst  = (MAX_CHANNELS >= 2) ? 2 : 1;
  localparam int unsigned LimRst    = STORE_DEPTH / EffChRst;
  localparam int unsigned EffCapRst = (LimRst < 2048) ? LimRst : 2048;
  localparam int unsigned SpanRst   = EffCapRst * EffChRst;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [SW-1:0] span);
    logic [SW-1:0] n;
    n = {1'b0, p} + SW'(1);
    return (n >= span) ? '0 : n[AW-1:0];
  endfunction

  function automatic logic [CapW-1:0] frames_free(input logic [CapW-1:0] used,
                                                  input logic taken,
                                                  input logic [CapW-1:0] cap);
    logic [CapW:0] t;
    t = {1'b0, used} + (CapW+1)'(1) + {{CapW{1'b0}}, taken};
    return ({1'b0, cap} > t) ? CapW'({1'b0, cap} - t) : '0;
  endfunction

  // Frame-slot limit for each channel count.
  logic [SW-1:0] lim_tab [8];
  for (genvar g = 0; g < 8; g++) begin : g_lim
    localparam int unsigned Lim = STORE_DEPTH / (g + 1);
    assign lim_tab[g] = SW'(Lim);
  end

  logic [ChW-1:0]  ch_raw_q, ch_raw_d;
  logic [CapW-1:0] cap_raw_q, cap_raw_d;
  logic [ChW-1:0]  eff_ch_q, eff_ch_d;
  logic [CapW-1:0] eff_cap_q, eff_cap_d;
  logic [SW-1:0]   span_q, span_d;
  logic [16:0]     span_prod;
  logic [SW-1:0]   lim;
  logic [CapW-1:0] cap_nz;

  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CapW-1:0] used_q, used_d;
  logic [WchW-1:0] wr_ch_q, wr_ch_d;
  logic            taken_q, taken_d;
  logic [WchW-1:0] k_q, k_d;
  logic            hit_q, hit_d;

  logic [31:0]     sample_q, sample_d;
  logic            out_valid_q, out_valid_d;
  status_e         out_status_q, out_status_d;
  logic            out_last_q, out_last_d;
  logic            out_hit_q, out_hit_d;

  logic            mem_we, mem_re;
  logic [31:0]     mem_rdata;
  logic [CapW-1:0] free_now;
  logic            take;
  logic [ChW-1:0]  ch_next;
  logic            frame_end;
  logic            rd_hit;
  logic            rd_last;

  // Effective geometry, one stage behind the raw registers, span one more.
  always_comb begin
    if (ch_raw_q == '0) begin
      eff_ch_d = ChW'(1);
    end else if (ch_raw_q > ChW'(MAX_CHANNELS)) begin
      eff_ch_d = ChW'(MAX_CHANNELS);
    end else begin
      eff_ch_d = ch_raw_q;
    end
    lim    = lim_tab[WchW'(eff_ch_d - ChW'(1))];
    cap_nz = (cap_raw_q == '0) ? CapW'(1) : cap_raw_q;
    eff_cap_d = (CMPW'(cap_nz) > CMPW'(lim)) ? CapW'(lim) : cap_nz;
    span_prod = 17'(eff_cap_q) * 17'(eff_ch_q);
    span_d    = SW'(span_prod);
  end

  assign free_now  = frames_free(used_q, taken_q, eff_cap_q);
  assign take      = (wr_ch_q == '0) ? (free_now != '0) : taken_q;
  assign ch_next   = {1'b0, wr_ch_q} + ChW'(1);
  assign frame_end = ch_next >= eff_ch_q;
  assign rd_hit    = (k_q == '0) ? (used_q != '0) : hit_q;
  assign rd_last   = ({1'b0, k_q} + ChW'(1)) == eff_ch_q;

  assign dp_status_o.rd_last = rd_last;

  always_comb begin
    ch_raw_d     = ch_raw_q;
    cap_raw_d    = cap_raw_q;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    used_d       = used_q;
    wr_ch_d      = wr_ch_q;
    taken_d      = taken_q;
    k_d          = k_q;
    hit_d        = hit_q;
    sample_d     = sample_q;
    out_valid_d  = 1'b0;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    out_hit_d    = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;

    if (dp_cmd_i.load) begin
      sample_d = sample_i;
    end

    if (dp_cmd_i.wr) begin
      mem_we = take;
      if (take) begin
        wr_ptr_d = adv(wr_ptr_q, span_q);
      end
      if (frame_end) begin
        wr_ch_d = '0;
        taken_d = 1'b0;
        if (take) begin
          used_d = used_q + CapW'(1);
        end
      end else begin
        wr_ch_d = WchW'(ch_next);
        taken_d = take;
      end
      out_valid_d  = 1'b1;
      out_status_d = take ? ST_WRITTEN : ST_DROPPED;
      out_last_d   = 1'b1;
    end

    if (dp_cmd_i.rd) begin
      mem_re = rd_hit;
      if (k_q == '0) begin
        hit_d = rd_hit;
        if (rd_hit) begin
          used_d = used_q - CapW'(1);
        end
      end
      if (rd_hit) begin
        rd_ptr_d = adv(rd_ptr_q, span_q);
      end
      k_d          = rd_last ? '0 : k_q + WchW'(1);
      out_valid_d  = 1'b1;
      out_status_d = rd_hit ? ST_READ_DATA : ST_SILENCE;
      out_last_d   = rd_last;
      out_hit_d    = rd_hit;
    end

    if (dp_cmd_i.clr) begin
      wr_ptr_d     = '0;
      rd_ptr_d     = '0;
      used_d       = '0;
      wr_ch_d      = '0;
      taken_d      = 1'b0;
      out_valid_d  = 1'b1;
      out_status_d = ST_CLEARED;
      out_last_d   = 1'b1;
    end

    // a register write empties the ring so pointers fit the new geometry
    if (cfg_we_i) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      used_d   = '0;
      wr_ch_d  = '0;
      taken_d  = 1'b0;
      k_d      = '0;
      if (cfg_idx_i == CFG_CHANNELS) begin
        ch_raw_d = cfg_data_i[ChW-1:0];
      end else begin
        cap_raw_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_raw_q    <= ChW'(2);
      cap_raw_q   <= CapW'(2048);
      eff_ch_q    <= ChW'(EffChRst);
      eff_cap_q   <= CapW'(EffCapRst);
      span_q      <= SW'(SpanRst);
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      used_q      <= '0;
      wr_ch_q     <= '0;
      taken_q     <= 1'b0;
      k_q         <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
    end else begin
      ch_raw_q    <= ch_raw_d;
      cap_raw_q   <= cap_raw_d;
      eff_ch_q    <= eff_ch_d;
      eff_cap_q   <= eff_cap_d;
      span_q      <= span_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      used_q      <= used_d;
      wr_ch_q     <= wr_ch_d;
      taken_q     <= taken_d;
      k_q         <= k_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      out_hit_q   <= out_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q     <= sample_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  mcff_ram #(
    .WIDTH (32),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (sample_q),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  assign result_valid_o    = out_valid_q;
  assign status_o          = out_status_q;
  assign last_o            = out_last_q;
  assign sample_out_o      = out_hit_q ? mem_rdata : '0;
  assign frames_readable_o = used_q;
  assign frames_writable_o = free_now[11:0];

  a_used_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q < eff_cap_q)
    else $error("stored frame count reached the ring capacity");

  a_ptr_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, wr_ptr_q} < span_q) && ({1'b0, rd_ptr_q} < span_q))
    else $error("ring pointer outside the active span");

  a_taken_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_q |-> (wr_ch_q != '0))
    else $error("frame marked accepted outside a partial frame");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the multichannel frame FIFO: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import mcff_pkg::*;

  localparam int unsigned STORE_DEPTH  = 4096;
  localparam int unsigned MAX_CHANNELS = 8;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  // Cycles to let pass after the last word when draining, before touching config; doubled before ending.
  localparam int unsigned SETTLE       = 6;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_WORDS = 450;
  // Past this many random words, drop all idling.
  localparam int unsigned CALM_AFTER   = 380;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          cmd_i;
  logic [31:0]         sample_i;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [CapW-1:0]     cfg_data_i;
  logic                result_valid_o;
  logic [2:0]          status_o;
  logic [31:0]         sample_out_o;
  logic                last_o;
  logic [12:0]         frames_readable_o;
  logic [11:0]         frames_writable_o;

  multichannel_frame_fifo #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cmd_i            (cmd_i),
    .sample_i         (sample_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .sample_out_o     (sample_out_o),
    .last_o           (last_o),
    .frames_readable_o(frames_readable_o),
    .frames_writable_o(frames_writable_o)
  );

  // One result word as the block should present it.
  typedef struct {
    status_e     status;
    logic [31:0] smp;
    logic        fin;
    logic [12:0] readable;
    logic [11:0] writable;
  } word_t;

  // One row of the directed plan: either a command or a register write.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  op;
    cfg_idx_e    sel;
    logic [31:0] data;
    bit          typed;
    status_e     st;
    logic [12:0] rdbl;
    logic [11:0] wrbl;
  } row_t;

  word_t       due_words[$];
  row_t        plan[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          calm;

  // Predicted ring state and register copies.
  logic [31:0] ring_mem [STORE_DEPTH];
  logic [11:0] wr_ptr;
  logic [11:0] rd_ptr;
  logic [12:0] frames_held;
  logic [3:0]  fill_pos;
  logic        frame_open;
  logic [3:0]  chan_reg;
  logic [12:0] cap_reg;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring predictor
  // ---------------------------------------------------------------------------

  // Channel count as the block uses it: zero counts as one, clamp to the max.
  function automatic int unsigned lanes();
    int unsigned c;
    c = chan_reg;
    if (c == 0) c = 1;
    if (c > MAX_CHANNELS) c = MAX_CHANNELS;
    return c;
  endfunction

  // Frame slots in the ring, clamped so the frames fit the store.
  function automatic int unsigned slots();
    int unsigned c;
    int unsigned lim;
    c = cap_reg;
    lim = STORE_DEPTH / lanes();
    if (c == 0) c = 1;
    if (c > lim) c = lim;
    return c;
  endfunction

  // Free slots beyond the reserved one and the frame being filled.
  function automatic int unsigned free_slots();
    int unsigned taken;
    taken = frames_held + 1 + frame_open;
    return (taken >= slots()) ? 0 : slots() - taken;
  endfunction

  function automatic logic [11:0] step_ptr(int unsigned p, int unsigned by);
    int unsigned span;
    int unsigned n;
    span = slots() * lanes();
    n = p + by;
    while (n >= span) n -= span;
    return n[11:0];
  endfunction

  // Counts are taken from the state after the command has been applied.
  function automatic void push_word(status_e st, logic [31:0] s, logic fin);
    word_t w;
    w.status   = st;
    w.smp      = s;
    w.fin      = fin;
    w.readable = frames_held;
    w.writable = 12'(free_slots());
    due_words.push_back(w);
  endfunction

  function automatic void empty_ring();
    wr_ptr      = '0;
    rd_ptr      = '0;
    frames_held = '0;
    fill_pos    = '0;
    frame_open  = 1'b0;
  endfunction

  // Apply one accepted command and queue the words it must return.
  task automatic ring_step(input logic [1:0] op, input logic [31:0] s, output int n);
    logic [31:0] vals [MAX_CHANNELS];
    status_e     st;
    int unsigned ch;
    ch = lanes();
    n  = 0;
    case (op)
      CMD_WRITE: begin
        // Admit or drop the whole frame on its first sample.
        if (fill_pos == 0) frame_open = (free_slots() >= 1);
        if (frame_open) begin
          ring_mem[wr_ptr] = s;
          wr_ptr = step_ptr(wr_ptr, 1);
          st = ST_WRITTEN;
        end else begin
          st = ST_DROPPED;
        end
        fill_pos = fill_pos + 4'd1;
        if (fill_pos >= ch) begin
          fill_pos = '0;
          if (frame_open) begin
            frame_open  = 1'b0;
            frames_held = frames_held + 13'd1;
          end
        end
        push_word(st, 32'h0, 1'b1);
        n = 1;
      end
      CMD_READ: begin
        if (frames_held >= 1) begin
          for (int k = 0; k < ch; k++) vals[k] = ring_mem[step_ptr(rd_ptr, k)];
          rd_ptr = step_ptr(rd_ptr, ch);
          frames_held = frames_held - 13'd1;
          st = ST_READ_DATA;
        end else begin
          for (int k = 0; k < ch; k++) vals[k] = 32'h0;
          st = ST_SILENCE;
        end
        for (int k = 0; k < ch; k++) push_word(st, vals[k], k + 1 == ch);
        n = ch;
      end
      CMD_CLEAR: begin
        empty_ring();
        push_word(ST_CLEARED, 32'h0, 1'b1);
        n = 1;
      end
      default: ;  // unknown command: no words
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: the receiver never stalls, so take every strobed word.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && result_valid_o) begin
      if (due_words.size() == 0) begin
        $display("%0t: expected no word, got status %0d sample %h", $time, status_o,
                 sample_out_o);
        mismatches++;
      end else begin
        w = due_words.pop_front();
        if (status_o !== w.status) begin
          $display("%0t: status expected %0d got %0d", $time, w.status, status_o);
          mismatches++;
        end
        if (sample_out_o !== w.smp) begin
          $display("%0t: sample expected %h got %h", $time, w.smp, sample_out_o);
          mismatches++;
        end
        if (last_o !== w.fin) begin
          $display("%0t: last expected %0d got %0d", $time, w.fin, last_o);
          mismatches++;
        end
        if (frames_readable_o !== w.readable) begin
          $display("%0t: readable expected %0d got %0d", $time, w.readable,
                   frames_readable_o);
          mismatches++;
        end
        if (frames_writable_o !== w.writable) begin
          $display("%0t: writable expected %0d got %0d", $time, w.writable,
                   frames_writable_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------

  // Hold start high until the block takes the word, then predict it.
  task automatic send_word(input logic [1:0] op, input logic [31:0] s, output int n);
    start_i  <= 1'b1;
    cmd_i    <= op;
    sample_i <= s;
    do @(posedge clk_i); while (busy_o);
    ring_step(op, s, n);
  endtask

  // Random idle burst after a word, unless this stretch runs without idling.
  task automatic rest();
    if (!calm && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Pause until every expected word has come and the block has settled.
  task automatic drain();
    start_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write one register while idle; any write also empties the ring.
  task automatic set_reg(input cfg_idx_e sel, input logic [12:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (sel == CFG_CHANNELS) chan_reg = data[3:0];
    else cap_reg = data;
    empty_ring();
  endtask

  function automatic row_t cmd_row(logic [1:0] op, logic [31:0] data, bit typed,
                                   status_e st, logic [12:0] rdbl, logic [11:0] wrbl);
    row_t r;
    r.is_cfg = 1'b0;
    r.op     = op;
    r.sel    = CFG_CHANNELS;
    r.data   = data;
    r.typed  = typed;
    r.st     = st;
    r.rdbl   = rdbl;
    r.wrbl   = wrbl;
    return r;
  endfunction

  function automatic row_t cfg_row(cfg_idx_e sel, logic [12:0] data);
    row_t r;
    r = cmd_row(CMD_WRITE, {19'h0, data}, 1'b0, ST_WRITTEN, '0, '0);
    r.is_cfg = 1'b1;
    r.sel    = sel;
    return r;
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          n;
    int unsigned sent;
    int unsigned ch;
    int unsigned pick;
    int unsigned phase_words;
    logic [12:0] cap_val;
    logic [3:0]  ch_val;

    rst_ni     <= 1'b0;
    start_i    <= 1'b0;
    cmd_i      <= CMD_WRITE;
    sample_i   <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_CHANNELS;
    cfg_data_i <= '0;
    cycles      = 0;
    mismatches  = 0;
    calm        = 1'b0;
    chan_reg    = 4'd2;
    cap_reg     = 13'd2048;
    empty_ring();

    // Directed plan. Defaults after reset: two channels, 2048 slots.
    plan.push_back(cmd_row(CMD_READ,   32'h0,         1, ST_SILENCE,   0, 2047));
    plan.push_back(cmd_row(CMD_CLEAR,  32'h0,         1, ST_CLEARED,   0, 2047));
    plan.push_back(cmd_row(CMD_UNUSED, 32'hFFFF_FFFF, 0, ST_WRITTEN,   0, 0));
    plan.push_back(cmd_row(CMD_WRITE,  32'h0000_0000, 1, ST_WRITTEN,   0, 2046));
    plan.push_back(cmd_row(CMD_WRITE,  32'hFFFF_FFFF, 1, ST_WRITTEN,   1, 2046));
    plan.push_back(cmd_row(CMD_READ,   32'h0,         0, ST_READ_DATA, 0, 0));
    // Clear in the middle of a frame discards the partial frame.
    plan.push_back(cmd_row(CMD_WRITE,  32'hA5A5_A5A5, 0, ST_WRITTEN,   0, 0));
    plan.push_back(cmd_row(CMD_CLEAR,  32'h0,         1, ST_CLEARED,   0, 2047));
    plan.push_back(cmd_row(CMD_WRITE,  32'h5A5A_5A5A, 0, ST_WRITTEN,   0, 0));
    plan.push_back(cmd_row(CMD_WRITE,  32'h1234_5678, 0, ST_WRITTEN,   0, 0));
    // Read while the next frame is half written returns only complete frames.
    plan.push_back(cmd_row(CMD_WRITE,  32'h8000_0001, 0, ST_WRITTEN,   0, 0));
    plan.push_back(cmd_row(CMD_READ,   32'h0,         0, ST_READ_DATA, 0, 0));
    plan.push_back(cmd_row(CMD_WRITE,  32'h7FFF_FFFE, 0, ST_WRITTEN,   0, 0));
    plan.push_back(cmd_row(CMD_READ,   32'h0,         0, ST_READ_DATA, 0, 0));
    // Zero channels and zero capacity act as one: a one-slot ring drops all.
    plan.push_back(cfg_row(CFG_CHANNELS, 13'd0));
    plan.push_back(cfg_row(CFG_CAPACITY, 13'd0));
    plan.push_back(cmd_row(CMD_WRITE,  32'hDEAD_BEEF, 1, ST_DROPPED,   0, 0));
    plan.push_back(cmd_row(CMD_READ,   32'h0,         1, ST_SILENCE,   0, 0));
    // Two slots: one frame fits, the next is dropped by the reserved slot.
    plan.push_back(cfg_row(CFG_CAPACITY, 13'd2));
    plan.push_back(cmd_row(CMD_WRITE,  32'h0F0F_0F0F, 1, ST_WRITTEN,   1, 0));
    plan.push_back(cmd_row(CMD_WRITE,  32'hF0F0_F0F0, 1, ST_DROPPED,   1, 0));
    plan.push_back(cmd_row(CMD_READ,   32'h0,         0, ST_READ_DATA, 0, 0));
    // Channel count above the max clamps to eight; capacity clamps to 512.
    plan.push_back(cfg_row(CFG_CHANNELS, 13'd15));
    plan.push_back(cfg_row(CFG_CAPACITY, 13'h1FFF));
    plan.push_back(cmd_row(CMD_READ,   32'h0,         1, ST_SILENCE,   0, 511));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_reg(plan[i].sel, plan[i].data[12:0]);
      end else begin
        send_word(plan[i].op, plan[i].data, n);
        // Override the predicted fields where the row spells them out.
        if (plan[i].typed) begin
          for (int k = due_words.size() - n; k < due_words.size(); k++) begin
            due_words[k].status   = plan[i].st;
            due_words[k].readable = plan[i].rdbl;
            due_words[k].writable = plan[i].wrbl;
          end
        end
        rest();
      end
    end

    // Random phases: fresh geometry each phase, mostly whole frames and reads.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) ch_val = 4'd0;
      else if (pick == 1) ch_val = 4'($urandom_range(9, 15));
      else ch_val = 4'($urandom_range(1, 8));
      pick = $urandom_range(0, 19);
      if (pick == 0) cap_val = 13'd0;
      else if (pick == 1) cap_val = $urandom_range(0, 1) ? 13'h1FFF : 13'd4096;
      else if (pick < 5) cap_val = 13'($urandom_range(7, 300));
      else cap_val = 13'($urandom_range(1, 6));
      if ($urandom_range(0, 1)) begin
        set_reg(CFG_CHANNELS, {9'h0, ch_val});
        set_reg(CFG_CAPACITY, cap_val);
      end else begin
        set_reg(CFG_CAPACITY, cap_val);
        set_reg(CFG_CHANNELS, {9'h0, ch_val});
      end
      calm = ($urandom_range(0, 3) == 0) || (sent > CALM_AFTER);

      phase_words = 0;
      while (phase_words < 50 && sent < RANDOM_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          // Whole frame; now and then cut short to leave a partial frame.
          ch = lanes();
          if ($urandom_range(0, 19) == 0) ch = $urandom_range(1, ch);
          repeat (ch) begin
            send_word(CMD_WRITE, pick_sample(), n);
            sent++;
            phase_words++;
            rest();
          end
        end else begin
          if (pick < 82) send_word(CMD_READ, $urandom, n);
          else if (pick < 87) send_word(CMD_CLEAR, $urandom, n);
          else if (pick < 90) send_word(CMD_UNUSED, $urandom, n);
          else send_word(CMD_WRITE, pick_sample(), n);
          if (n != 0) begin
            sent++;
            phase_words++;
          end
          rest();
        end
        if (sent <= CALM_AFTER && $urandom_range(0, 49) == 0) drain();
        if (sent > CALM_AFTER) calm = 1'b1;
      end
    end

    start_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mcff_pkg.sv
rtl/core/mcff_ram.sv
rtl/core/mcff_ctrl.sv
rtl/core/mcff_datapath.sv
rtl/core/multichannel_frame_fifo.sv
dv/tb_top.sv
